// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle.
`define CHK_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication checked in the next cycle.
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/rsl_pkg.sv =====
// Types and constants of the run-sliced line generator.
package rsl_pkg;

  localparam int CB    = 12;          // coordinate bits
  localparam int LW    = CB + 1;      // run length bits
  localparam int ETW   = CB + 3;      // error term bits
  localparam int CNT_W = $clog2(CB);  // divider step counter

  localparam logic OP_START = 1'b0;
  localparam logic OP_NEXT  = 1'b1;

  localparam logic [1:0] KIND_HORZ = 2'd0;
  localparam logic [1:0] KIND_VERT = 2'd1;
  localparam logic [1:0] KIND_DIAG = 2'd2;

  typedef struct packed {
    logic                 op;
    logic signed [CB-1:0] x_start;
    logic signed [CB-1:0] y_start;
    logic signed [CB-1:0] x_end;
    logic signed [CB-1:0] y_end;
  } cmd_t;

  typedef struct packed {
    logic signed [CB-1:0] run_x;
    logic signed [CB-1:0] run_y;
    logic [LW-1:0]        run_length;
    logic [1:0]           run_kind;
    logic                 diag_right;
    logic                 last_run;
  } run_t;

endpackage

// ===== rtl/run_sliced_line_generator_core.sv =====
// Run-sliced line generator: sequencer, shared divider and run stepper.
//
//  channel | dir | handshake           | word
//  cmd     | in  | cmd_valid/cmd_stall | rsl_pkg::cmd_t
//  run     | out | run_valid/run_stall | rsl_pkg::run_t
//
// A next word, and a start word for a single-run line, go from S_IDLE straight to S_OUT.
// A start word for a sliced line goes through S_DIV, where the restoring divider
// works out major/minor one quotient bit per cycle, then S_SETUP and S_OUT.
// cmd_stall is high from acceptance until the result reaches the run register.
// A stalled run word holds the result in the sequencer; the next command waits.
// Reset clears the sequencer, the line-active flag and run_valid.
module run_sliced_line_generator_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  rsl_pkg::cmd_t cmd,
  output logic          run_valid,
  input  logic          run_stall,
  output rsl_pkg::run_t run
);
  import rsl_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_SETUP, S_OUT} state_t;

  state_t          state;
  logic [CNT_W-1:0] cnt;
  logic [CB:0]     acc;
  logic [CB-1:0]   quo;
  logic [CB-1:0]   minor;
  logic [CB-1:0]   cur_x;
  logic [CB-1:0]   cur_y;
  logic [ETW-1:0]  error_term;
  logic [CB:0]     adjust_up;
  logic [CB+1:0]   adjust_down;
  logic [CB-1:0]   base_run;
  logic [CB-1:0]   final_run;
  logic [CB-1:0]   runs_left;
  logic            step_left;
  logic            x_major;
  logic            busy;
  run_t            res;

  // Start decode: order endpoints top to bottom
  logic          swap;
  logic [CB-1:0] x1, y1, x2, y2;
  logic [CB:0]   dy_w, dx_w, adx_w;
  logic [CB-1:0] dy, adx;
  logic          left, dx_zero, dy_zero, is_diag, xmaj;

  always_comb begin
    swap    = cmd.y_start > cmd.y_end;
    x1      = swap ? cmd.x_end : cmd.x_start;
    y1      = swap ? cmd.y_end : cmd.y_start;
    x2      = swap ? cmd.x_start : cmd.x_end;
    y2      = swap ? cmd.y_start : cmd.y_end;
    dy_w    = {y2[CB-1], y2} - {y1[CB-1], y1};
    dx_w    = {x2[CB-1], x2} - {x1[CB-1], x1};
    left    = dx_w[CB];
    adx_w   = left ? (~dx_w + (CB+1)'(1)) : dx_w;
    dy      = dy_w[CB-1:0];
    adx     = adx_w[CB-1:0];
    dx_zero = (dx_w == '0);
    dy_zero = (dy == '0);
    is_diag = (adx == dy);
    xmaj    = (adx > dy);
  end

  // Divider step: shift in one dividend bit, trial subtract
  logic [CB:0]   sh;
  logic [CB+1:0] diff_w;
  logic          ge;

  always_comb begin
    sh     = {acc[CB-1:0], quo[CB-1]};
    diff_w = {1'b0, sh} - {2'b00, minor};
    ge     = !diff_w[CB+1];
  end

  // Set-up values from quotient and remainder
  logic [LW-1:0]  first_len;
  logic [ETW-1:0] et_setup;

  always_comb begin
    first_len = {2'b00, quo[CB-1:1]} + LW'(1);
    if (!quo[0] && acc[CB-1:0] == '0) first_len = first_len - LW'(1);
    et_setup = {{(ETW-CB){1'b0}}, acc[CB-1:0]} - {{(ETW-CB-1){1'b0}}, minor, 1'b0};
    if (quo[0]) et_setup = et_setup + {{(ETW-CB){1'b0}}, minor};
  end

  // Middle run: error accumulate and compare
  logic [ETW-1:0] et_add, et_next;
  logic           et_pos;
  logic [LW-1:0]  next_len;

  always_comb begin
    et_add   = error_term + {{(ETW-CB-1){1'b0}}, adjust_up};
    et_pos   = !et_add[ETW-1] && (et_add != '0);
    next_len = {1'b0, base_run} + LW'(et_pos);
    et_next  = et_pos ? et_add - {{(ETW-CB-2){1'b0}}, adjust_down} : et_add;
  end

  // Shared run emitter
  logic          em_last;
  logic [LW-1:0] em_len;
  logic [CB-1:0] len_c, nx, ny;
  run_t          em_run;

  always_comb begin
    em_last = (state != S_SETUP) && (runs_left == '0);
    if (state == S_SETUP)       em_len = first_len;
    else if (runs_left != '0)   em_len = next_len;
    else                        em_len = {1'b0, final_run};
    len_c = em_len[CB-1:0];
    em_run.run_length = em_len;
    em_run.run_y      = cur_y;
    em_run.diag_right = 1'b0;
    em_run.last_run   = em_last;
    if (x_major) begin
      em_run.run_x    = step_left ? cur_x - len_c + CB'(1) : cur_x;
      em_run.run_kind = KIND_HORZ;
      nx = step_left ? cur_x - len_c : cur_x + len_c;
      ny = cur_y + CB'(1);
    end else begin
      em_run.run_x    = cur_x;
      em_run.run_kind = KIND_VERT;
      nx = step_left ? cur_x - CB'(1) : cur_x + CB'(1);
      ny = cur_y + len_c;
    end
  end

  assign cmd_stall = (state != S_IDLE);

  // Sequencer and registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      busy      <= 1'b0;
      run_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (run_valid && !run_stall && state != S_OUT) run_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            if (cmd.op == OP_START) begin
              busy  <= 1'b0;
              res.last_run   <= 1'b1;
              res.run_y      <= y1;
              if (dx_zero) begin
                state          <= S_OUT;
                res.run_x      <= x1;
                res.run_length <= {1'b0, dy} + LW'(1);
                res.run_kind   <= KIND_VERT;
                res.diag_right <= 1'b0;
              end else if (dy_zero) begin
                state          <= S_OUT;
                res.run_x      <= left ? x2 : x1;
                res.run_length <= {1'b0, adx} + LW'(1);
                res.run_kind   <= KIND_HORZ;
                res.diag_right <= 1'b0;
              end else if (is_diag) begin
                state          <= S_OUT;
                res.run_x      <= x1;
                res.run_length <= {1'b0, adx} + LW'(1);
                res.run_kind   <= KIND_DIAG;
                res.diag_right <= !left;
              end else begin
                x_major   <= xmaj;
                step_left <= left;
                cur_x     <= x1;
                cur_y     <= y1;
                quo       <= xmaj ? adx : dy;
                minor     <= xmaj ? dy : adx;
                acc       <= '0;
                cnt       <= CNT_W'(CB - 1);
                state     <= S_DIV;
              end
            end else begin
              state <= S_OUT;
              if (!busy) begin
                res <= '{run_x: '0, run_y: '0, run_length: '0, run_kind: KIND_HORZ,
                         diag_right: 1'b0, last_run: 1'b1};
              end else begin
                res   <= em_run;
                cur_x <= nx;
                cur_y <= ny;
                if (runs_left != '0) begin
                  error_term <= et_next;
                  runs_left  <= runs_left - CB'(1);
                end else begin
                  busy <= 1'b0;
                end
              end
            end
          end
        end
        S_DIV: begin
          acc <= ge ? diff_w[CB:0] : sh;
          quo <= {quo[CB-2:0], ge};
          if (cnt == '0) state <= S_SETUP;
          else           cnt   <= cnt - CNT_W'(1);
        end
        S_SETUP: begin
          base_run    <= quo;
          adjust_up   <= {acc[CB-1:0], 1'b0};
          adjust_down <= {1'b0, minor, 1'b0};
          error_term  <= et_setup;
          final_run   <= {1'b0, quo[CB-1:1]} + CB'(1);
          runs_left   <= minor - CB'(1);
          busy        <= 1'b1;
          res         <= em_run;
          cur_x       <= nx;
          cur_y       <= ny;
          state       <= S_OUT;
        end
        S_OUT: begin
          if (!run_valid || !run_stall) begin
            run       <= res;
            run_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/rsl_checker.sv =====
// Port-level checks for the run-sliced line generator, bound to the top level.
`include "assert_macros.svh"

module rsl_checker (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_stall,
  input logic          run_valid,
  input logic          run_stall,
  input rsl_pkg::run_t run
);
  import rsl_pkg::*;

  // a stalled result word stays offered
  `CHK_NEXT(a_run_hold, clk, rst, run_valid && run_stall, run_valid)
  // one word in work at a time: stall follows every accepted command
  `CHK_NEXT(a_cmd_busy, clk, rst, cmd_valid && !cmd_stall, cmd_stall)
  // only the idle reply has zero length, and it is always marked last
  `CHK_SAME(a_zero_last, clk, rst, run_valid && run.run_length == '0, run.last_run)
  // step direction only on diagonal runs
  `CHK_SAME(a_diag_dir, clk, rst, run_valid && run.diag_right, run.run_kind == KIND_DIAG)
  // no undefined run kind
  `CHK_SAME(a_kind_ok, clk, rst, run_valid,
    run.run_kind == KIND_HORZ || run.run_kind == KIND_VERT || run.run_kind == KIND_DIAG)

endmodule

bind run_sliced_line_generator_core rsl_checker u_rsl_checker (.*);

// ===== test/tb.sv =====
// Self-checking bench for the run-sliced line generator: random line commands and run checks.
module tb;
  import rsl_pkg::*;

  localparam int RANDOM_WORDS = 500;
  localparam int IDLE_LIMIT   = 500;   // cycles with no word moving on either channel
  localparam int TAIL_CYCLES  = 40;

  typedef struct {
    cmd_t word;
    bit   drain;   // hold this word back until every run due has come out
  } pending_t;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  logic clk;
  logic rst       = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd       = '0;
  logic run_valid;
  logic run_stall = 1'b0;
  run_t run;

  pending_t cmd_backlog[$];
  run_t     runs_due[$];

  int total_words   = 0;
  int sent_cnt      = 0;
  int took_cnt      = 0;
  int words_checked = 0;
  int mismatches    = 0;
  int idle_cycles   = 0;
  int burst_left    = 0;
  int gap_left      = 0;
  int stall_phase   = 0;
  stall_mode_t stall_mode = STALL_NONE;

  // Line state of the predictor
  int   ln_x, ln_y;
  int   ln_err;
  int   ln_adj_up;
  int   ln_adj_dn;
  int   ln_base, ln_final, ln_runs_left;
  logic ln_left, ln_xmaj, ln_busy;

  run_sliced_line_generator_core uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .run_valid (run_valid),
    .run_stall (run_stall),
    .run       (run)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic run_t pack_run(int x, int y, int len, logic [1:0] kind,
                                    logic right, logic last);
    run_t r;
    r.run_x      = x[CB-1:0];
    r.run_y      = y[CB-1:0];
    r.run_length = len[LW-1:0];
    r.run_kind   = kind;
    r.diag_right = right;
    r.last_run   = last;
    return r;
  endfunction

  // Emit one slice from the current origin and move the origin past it
  function automatic run_t slice_out(int len, logic last);
    run_t r;
    int   rx;
    if (ln_xmaj) begin
      rx = ln_left ? int'(ln_x) - len + 1 : int'(ln_x);
      r = pack_run(rx, int'(ln_y), len, KIND_HORZ, 1'b0, last);
      ln_x = ln_left ? int'(ln_x) - len : int'(ln_x) + len;
      ln_y = int'(ln_y) + 1;
    end else begin
      r = pack_run(int'(ln_x), int'(ln_y), len, KIND_VERT, 1'b0, last);
      ln_y = int'(ln_y) + len;
      ln_x = ln_left ? int'(ln_x) - 1 : int'(ln_x) + 1;
    end
    return r;
  endfunction

  // Expected run word for one accepted command word
  function automatic run_t trace_run(cmd_t w);
    int   x1, y1, x2, y2, t, dy, dx, adx, major, minor, rem_v, first, len, err;
    logic left;
    run_t r;
    if (w.op == OP_START) begin
      x1 = int'(w.x_start);
      y1 = int'(w.y_start);
      x2 = int'(w.x_end);
      y2 = int'(w.y_end);
      // order the endpoints top to bottom
      if (y1 > y2) begin
        t = y1; y1 = y2; y2 = t;
        t = x1; x1 = x2; x2 = t;
      end
      dy = y2 - y1;
      dx = x2 - x1;
      left = dx < 0;
      adx = left ? -dx : dx;
      ln_busy = 1'b0;
      if (dx == 0) return pack_run(x1, y1, dy + 1, KIND_VERT, 1'b0, 1'b1);
      if (dy == 0) return pack_run(left ? x2 : x1, y1, adx + 1, KIND_HORZ, 1'b0, 1'b1);
      if (adx == dy) return pack_run(x1, y1, adx + 1, KIND_DIAG, !left, 1'b1);
      // sliced line: whole runs of major/minor, remainder spread by the error term
      ln_xmaj = adx > dy;
      major = ln_xmaj ? adx : dy;
      minor = ln_xmaj ? dy : adx;
      ln_base = major / minor;
      rem_v = major % minor;
      ln_adj_up = rem_v + rem_v;
      ln_adj_dn = minor + minor;
      err = rem_v - 2 * minor;
      first = major / minor / 2 + 1;
      ln_final = first;
      if ((major / minor) % 2 == 1) err = err + minor;
      else if (rem_v == 0) first = first - 1;
      ln_err = err;
      ln_runs_left = minor - 1;
      ln_left = left;
      ln_x = x1;
      ln_y = y1;
      ln_busy = 1'b1;
      return slice_out(first, 1'b0);
    end
    // next word with no line in progress
    if (!ln_busy) return pack_run(0, 0, 0, KIND_HORZ, 1'b0, 1'b1);
    if (ln_runs_left > 0) begin
      len = int'(ln_base);
      err = int'(ln_err) + int'(ln_adj_up);
      if (err > 0) begin
        len = len + 1;
        err = err - int'(ln_adj_dn);
      end
      ln_err = err;
      ln_runs_left = ln_runs_left - 1;
      return slice_out(len, 1'b0);
    end
    r = slice_out(int'(ln_final), 1'b1);
    ln_busy = 1'b0;
    return r;
  endfunction

  task automatic flag(string msg);
    $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic signed [31:0] got,
                             logic signed [31:0] want);
    if (got !== want)
      flag($sformatf("run word %0d field %s: got %0d, want %0d",
                     words_checked, name, got, want));
  endtask

  function automatic int rand_coord();
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  // Offset a coordinate by d in a random direction, staying on the grid
  function automatic int fit(int c, int d);
    int t;
    if ($urandom_range(0, 1)) d = -d;
    t = c + d;
    if (t > 2047 || t < -2048) t = c - d;
    return t;
  endfunction

  task automatic push_word(cmd_t w, bit drain);
    pending_t p;
    p.word  = w;
    p.drain = drain;
    cmd_backlog.push_back(p);
  endtask

  // Next word: endpoint fields carry junk that the block must ignore
  task automatic push_next();
    cmd_t w;
    w.op      = OP_NEXT;
    w.x_start = CB'($urandom);
    w.y_start = CB'($urandom);
    w.x_end   = CB'($urandom);
    w.y_end   = CB'($urandom);
    push_word(w, 1'b0);
  endtask

  task automatic queue_line(int x1, int y1, int x2, int y2, int nexts, bit drain);
    cmd_t w;
    w.op      = OP_START;
    w.x_start = x1[CB-1:0];
    w.y_start = y1[CB-1:0];
    w.x_end   = x2[CB-1:0];
    w.y_end   = y2[CB-1:0];
    push_word(w, drain);
    repeat (nexts) push_next();
  endtask

  // Command driver: bursts with random gaps, holds a word until it is taken
  always @(negedge clk) begin : driver
    pending_t nxt;
    if (!rst && !(cmd_valid && took_cnt != sent_cnt)) begin
      if (gap_left > 0) begin
        gap_left--;
        cmd_valid <= 1'b0;
      end else if (cmd_backlog.size() == 0 ||
                   (cmd_backlog[0].drain && runs_due.size() != 0)) begin
        cmd_valid <= 1'b0;
      end else begin
        nxt = cmd_backlog.pop_front();
        cmd       <= nxt.word;
        cmd_valid <= 1'b1;
        sent_cnt++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 32);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Run receiver: stall pattern picks a new random mode whenever its phase counter runs out
  always @(negedge clk) begin
    if (rst) begin
      run_stall <= 1'b0;
    end else begin
      if (stall_phase == 0) begin
        stall_mode  = stall_mode_t'($urandom_range(0, 3));
        stall_phase = $urandom_range(8, 64);
      end
      stall_phase--;
      case (stall_mode)
        STALL_NONE:  run_stall <= 1'b0;
        STALL_COIN:  run_stall <= 1'($urandom_range(0, 1));
        STALL_HEAVY: run_stall <= (stall_phase % 8) != 0;
        default:     run_stall <= stall_phase[1];
      endcase
    end
  end

  // Monitor: check run words, then predict for the command word taken
  always @(posedge clk) begin : monitor
    run_t want;
    if (!rst) begin
      if (run_valid && !run_stall) begin
        if (runs_due.size() == 0) begin
          flag($sformatf("run word with nothing expected: %h", run));
        end else begin
          want = runs_due.pop_front();
          check_field("run_x", run.run_x, want.run_x);
          check_field("run_y", run.run_y, want.run_y);
          check_field("run_length", run.run_length, want.run_length);
          check_field("run_kind", run.run_kind, want.run_kind);
          check_field("diag_right", run.diag_right, want.diag_right);
          check_field("last_run", run.last_run, want.last_run);
          words_checked++;
        end
      end
      if (cmd_valid && !cmd_stall) begin
        runs_due.push_back(trace_run(cmd));
        took_cnt++;
      end
    end
  end

  // Watchdog on cycles where no word moves
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (run_valid && !run_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int  x1, y1, x2, y2, major, minor, nexts, pick, n_directed;
    bit  first_drain;
    first_drain = 1'b1;

    // directed: idle next, single-run lines at the extremes, sliced lines
    push_next();
    queue_line(0, 0, 0, 0, 0, 1'b0);                // single point
    queue_line(5, -2048, 5, 2047, 0, 1'b0);         // full-height vertical
    queue_line(2047, 10, -2048, 10, 0, 1'b0);       // right-to-left horizontal
    queue_line(-2048, -2048, 2047, 2047, 0, 1'b0);  // diagonal to the right
    queue_line(0, 100, 100, 0, 0, 1'b0);            // swapped, diagonal to the left
    queue_line(20, 7, 3, 2, 5 + 1, 1'b0);           // swapped x-major, then idle next
    queue_line(10, 0, 6, 13, 4, 1'b0);              // y-major stepping left
    queue_line(0, 0, 4, 2, 2, 1'b0);                // even base run, no remainder
    queue_line(0, 0, 30, 3, 1, 1'b0);               // dropped by the following start
    queue_line(-2048, -2048, 2047, -2047, 1, 1'b0); // longest x-major runs
    queue_line(2047, -2048, 2046, 2047, 1, 1'b0);   // longest y-major runs
    n_directed = cmd_backlog.size();

    // random: mostly complete lines, some cut short, some single runs and noise
    while (cmd_backlog.size() < n_directed + RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      x1 = rand_coord();
      y1 = rand_coord();
      if (pick < 85) begin
        if ($urandom_range(0, 9) == 0) begin
          minor = $urandom_range(1, 3);
          major = $urandom_range(100, 2047);
        end else begin
          minor = $urandom_range(1, 10);
          major = minor + $urandom_range(1, 40);
        end
        if ($urandom_range(0, 1)) begin
          x2 = fit(x1, major);
          y2 = fit(y1, minor);
        end else begin
          x2 = fit(x1, minor);
          y2 = fit(y1, major);
        end
        nexts = minor;
        if (pick < 70) nexts += ($urandom_range(0, 9) == 0);
        else nexts = $urandom_range(0, minor - 1);
        queue_line(x1, y1, x2, y2, nexts, first_drain || $urandom_range(0, 29) == 0);
        first_drain = 1'b0;
      end else if (pick < 95) begin
        case ($urandom_range(0, 2))
          0: begin x2 = x1; y2 = rand_coord(); end
          1: begin x2 = rand_coord(); y2 = y1; end
          default: begin
            major = $urandom_range(0, 2047);
            x2 = fit(x1, major);
            y2 = fit(y1, major);
          end
        endcase
        queue_line(x1, y1, x2, y2, $urandom_range(0, 1), 1'b0);
      end else if (pick < 98) begin
        queue_line(x1, y1, rand_coord(), rand_coord(), $urandom_range(0, 3), 1'b0);
      end else begin
        push_next();
      end
    end
    total_words = cmd_backlog.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (took_cnt != total_words || runs_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
